/* hw/rtl/pss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg: shared constants for the polygon scanline span unit
// coordinate width default and the minimum vertex count of a polygon
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int MIN_VERTICES    = 3;

endpackage
`default_nettype wire

/* hw/rtl/pss_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss channels: valid/ready stream interfaces
// vertex channel in, span result channel out
// ----------------------------------------------------------------------------
interface pss_vertex_if #(
    parameter int W = pss_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] vertex_s;
    logic signed [W-1:0] vertex_l;
    logic signed [W-1:0] query_s;
    logic                last_vertex;

    modport source (output valid, vertex_s, vertex_l, query_s, last_vertex, input ready);
    modport sink   (input valid, vertex_s, vertex_l, query_s, last_vertex, output ready);
endinterface

interface pss_result_if #(
    parameter int W = pss_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic                too_few_vertices;
    logic                hit;
    logic signed [W-1:0] span_min;
    logic signed [W-1:0] span_max;

    modport source (output valid, too_few_vertices, hit, span_min, span_max, input ready);
    modport sink   (input valid, too_few_vertices, hit, span_min, span_max, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pss_ser_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_ser_mul: bit-serial unsigned multiplier
// shift-add, one multiplier bit per cycle, full 2W-bit product
// ----------------------------------------------------------------------------
module pss_ser_mul #(
    parameter int W = pss_pkg::COORD_WIDTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [W-1:0]   mplier,
    input  wire logic [W-1:0]   mcand,
    output logic                done,
    output logic [2*W-1:0]      product
);
    localparam int CW = $clog2(W);

    logic [2*W-1:0] acc_reg;
    logic [W-1:0]   mplier_reg;
    logic [W-1:0]   mcand_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [W:0]     sum;

    // partial sum of the upper half, lsb of the multiplier selects the add
    assign sum = {1'b0, acc_reg[2*W-1:W]} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            mplier_reg <= '0;
            mcand_reg  <= '0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                acc_reg    <= '0;
                mplier_reg <= mplier;
                mcand_reg  <= mcand;
                cnt_reg    <= '0;
                busy_reg   <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg    <= {sum, acc_reg[W-1:1]};
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

/* hw/rtl/pss_ser_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_ser_div: bit-serial restoring divider
// 2W-bit dividend by W-bit divisor, quotient known to fit in W bits,
// one quotient bit per cycle shifted into the dividend low register
// ----------------------------------------------------------------------------
module pss_ser_div #(
    parameter int W = pss_pkg::COORD_WIDTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [2*W-1:0] dividend,
    input  wire logic [W-1:0]   divisor,
    output logic                done,
    output logic [W-1:0]        quotient
);
    localparam int CW = $clog2(W);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  shift_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    assign trial = {rem_reg, shift_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            shift_reg <= '0;
            den_reg   <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // upper half is below the divisor, so W steps suffice
                rem_reg   <= dividend[2*W-1:W];
                shift_reg <= dividend[W-1:0];
                den_reg   <= divisor;
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg   <= ge ? diff[W-1:0] : trial[W-1:0];
                shift_reg <= {shift_reg[W-2:0], ge};
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule
`default_nettype wire

/* hw/rtl/polygon_scanline_span_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_scanline_span_unit: lateral span of a polygon cut at one station
// vertices in, one min/max span result per polygon out
// ----------------------------------------------------------------------------
// Vertices arrive one per beat in polygon order; query_s is taken from the
// first vertex of each polygon and the beat with last_vertex closes it. One
// vertex is handled at a time. The first vertex of a polygon is only stored.
// Each later vertex evaluates one edge: an edge that misses the station goes
// straight on, a vertical edge takes its first vertex, and an edge that spans
// the station runs the bit-serial multiplier and then the bit-serial restoring
// divider, one bit per cycle each. The last vertex also evaluates the closing
// edge. The result sits in an output register, and the next polygon's
// vertices are taken while it waits.
// ----------------------------------------------------------------------------
module polygon_scanline_span_unit #(
    parameter int COORD_WIDTH = pss_pkg::COORD_WIDTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pss_vertex_if.sink  vertex,
    pss_result_if.source result
);
    import pss_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam logic signed [W-1:0] MAXV    = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] NEGMAXV = {1'b1, {(W-2){1'b0}}, 1'b1};
    localparam logic [1:0]          COUNT_SAT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_UPDATE,
        ST_AFTER,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic signed [W-1:0] first_s_reg, first_l_reg;
    logic signed [W-1:0] prev_s_reg, prev_l_reg;
    logic signed [W-1:0] cut_reg;
    logic [1:0]          vertex_count_reg;
    logic signed [W-1:0] run_min_reg, run_max_reg;
    logic                hit_seen_reg;
    logic                last_pending_reg;
    logic                closing_reg;
    logic                emit_few_reg;

    // edge under evaluation
    logic signed [W-1:0] e_s0_reg, e_l0_reg, e_s1_reg, e_l1_reg;
    logic [W-1:0]        den_reg;
    logic                up_reg;
    logic signed [W-1:0] l_reg;

    // result register
    logic                res_valid_reg;
    logic                res_few_reg;
    logic                res_hit_reg;
    logic signed [W-1:0] res_min_reg, res_max_reg;

    logic                gt_c, eq_c, in_range_c, up_c;
    logic [W-1:0]        num_c, den_c, dl_c;
    logic                mul_start, mul_done;
    logic [2*W-1:0]      product;
    logic                div_start, div_done;
    logic [W-1:0]        quot;

    // edge setup: direction, station test and operand magnitudes
    always_comb
    begin
        gt_c       = (e_s1_reg > e_s0_reg);
        eq_c       = (e_s1_reg == e_s0_reg);
        in_range_c = gt_c ? (cut_reg >= e_s0_reg && cut_reg <= e_s1_reg)
                          : (cut_reg >= e_s1_reg && cut_reg <= e_s0_reg);
        num_c      = gt_c ? W'(cut_reg - e_s0_reg) : W'(e_s0_reg - cut_reg);
        den_c      = gt_c ? W'(e_s1_reg - e_s0_reg) : W'(e_s0_reg - e_s1_reg);
        up_c       = (e_l1_reg >= e_l0_reg);
        dl_c       = up_c ? W'(e_l1_reg - e_l0_reg) : W'(e_l0_reg - e_l1_reg);
    end

    assign mul_start = (state_reg == ST_SETUP) && in_range_c && !eq_c;
    assign div_start = (state_reg == ST_MUL) && mul_done;

    pss_ser_mul #(.W(W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mplier  (num_c),
        .mcand   (dl_c),
        .done    (mul_done),
        .product (product)
    );

    pss_ser_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_s_reg      <= '0;
            first_l_reg      <= '0;
            prev_s_reg       <= '0;
            prev_l_reg       <= '0;
            cut_reg          <= '0;
            vertex_count_reg <= '0;
            run_min_reg      <= MAXV;
            run_max_reg      <= NEGMAXV;
            hit_seen_reg     <= 1'b0;
            last_pending_reg <= 1'b0;
            closing_reg      <= 1'b0;
            emit_few_reg     <= 1'b0;
            e_s0_reg         <= '0;
            e_l0_reg         <= '0;
            e_s1_reg         <= '0;
            e_l1_reg         <= '0;
            den_reg          <= '0;
            up_reg           <= 1'b0;
            l_reg            <= '0;
            res_valid_reg    <= 1'b0;
            res_few_reg      <= 1'b0;
            res_hit_reg      <= 1'b0;
            res_min_reg      <= '0;
            res_max_reg      <= '0;
        end
        else
        begin
            // in the emit state the result register is handled below
            if (result.ready && state_reg != ST_EMIT)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (vertex.valid)
                    begin
                        prev_s_reg <= vertex.vertex_s;
                        prev_l_reg <= vertex.vertex_l;
                        if (vertex_count_reg == 2'd0)
                        begin
                            cut_reg          <= vertex.query_s;
                            first_s_reg      <= vertex.vertex_s;
                            first_l_reg      <= vertex.vertex_l;
                            vertex_count_reg <= 2'd1;
                            if (vertex.last_vertex)
                            begin
                                emit_few_reg <= 1'b1;
                                state_reg    <= ST_EMIT;
                            end
                        end
                        else
                        begin
                            e_s0_reg         <= prev_s_reg;
                            e_l0_reg         <= prev_l_reg;
                            e_s1_reg         <= vertex.vertex_s;
                            e_l1_reg         <= vertex.vertex_l;
                            if (vertex_count_reg != COUNT_SAT)
                            begin
                                vertex_count_reg <= vertex_count_reg + 2'd1;
                            end
                            last_pending_reg <= vertex.last_vertex;
                            closing_reg      <= 1'b0;
                            state_reg        <= ST_SETUP;
                        end
                    end
                end
                ST_SETUP:
                begin
                    if (in_range_c)
                    begin
                        hit_seen_reg <= 1'b1;
                        up_reg       <= up_c;
                        den_reg      <= den_c;
                        if (eq_c)
                        begin
                            // vertical edge takes its first vertex
                            l_reg     <= e_l0_reg;
                            state_reg <= ST_UPDATE;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_AFTER;
                    end
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        l_reg     <= up_reg ? W'(e_l0_reg + quot) : W'(e_l0_reg - quot);
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (l_reg < run_min_reg)
                    begin
                        run_min_reg <= l_reg;
                    end
                    if (l_reg > run_max_reg)
                    begin
                        run_max_reg <= l_reg;
                    end
                    state_reg <= ST_AFTER;
                end
                ST_AFTER:
                begin
                    if (closing_reg)
                    begin
                        emit_few_reg <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end
                    else if (last_pending_reg)
                    begin
                        if (vertex_count_reg < 2'(MIN_VERTICES))
                        begin
                            emit_few_reg <= 1'b1;
                            state_reg    <= ST_EMIT;
                        end
                        else
                        begin
                            // closing edge from the last vertex back to the first
                            e_s0_reg    <= prev_s_reg;
                            e_l0_reg    <= prev_l_reg;
                            e_s1_reg    <= first_s_reg;
                            e_l1_reg    <= first_l_reg;
                            closing_reg <= 1'b1;
                            state_reg   <= ST_SETUP;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (!res_valid_reg || result.ready)
                    begin
                        res_valid_reg    <= 1'b1;
                        res_few_reg      <= emit_few_reg;
                        res_hit_reg      <= !emit_few_reg && hit_seen_reg;
                        res_min_reg      <= emit_few_reg ? MAXV : run_min_reg;
                        res_max_reg      <= emit_few_reg ? NEGMAXV : run_max_reg;
                        first_s_reg      <= '0;
                        first_l_reg      <= '0;
                        prev_s_reg       <= '0;
                        prev_l_reg       <= '0;
                        cut_reg          <= '0;
                        vertex_count_reg <= '0;
                        run_min_reg      <= MAXV;
                        run_max_reg      <= NEGMAXV;
                        hit_seen_reg     <= 1'b0;
                        last_pending_reg <= 1'b0;
                        closing_reg      <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign vertex.ready            = (state_reg == ST_IDLE);
    assign result.valid            = res_valid_reg;
    assign result.too_few_vertices = res_few_reg;
    assign result.hit              = res_hit_reg;
    assign result.span_min         = res_min_reg;
    assign result.span_max         = res_max_reg;

`ifndef SYNTHESIS
    // a new result always leaves the polygon state cleared behind it
    a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> (vertex_count_reg == 2'd0) && !hit_seen_reg)
        else $error("polygon state not cleared on result");

    a_few_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.too_few_vertices |-> !result.hit)
        else $error("hit reported for a degenerate polygon");

    // every hit edge feeds both min and max, so the span is ordered
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.hit |-> result.span_min <= result.span_max)
        else $error("span min above span max");
`endif

endmodule
`default_nettype wire
